@@ hdl/vdu_pkg.sv @@
// Shared types and constants for the vector distance unit.
`timescale 1ns / 1ps

package vdu_pkg;

    localparam int ELEM_W = 16;
    localparam int DIFF_W = ELEM_W + 1;
    localparam int TERM_W = 2 * DIFF_W;
    localparam int ACC_W  = 40;
    localparam int DIST_W = 24;
    localparam int MODE_W = 2;
    localparam int OP_W   = 2;

    // Mode register codes
    localparam logic [MODE_W-1:0] MODE_EUCLID    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd1;

    // Work codes passed from front to back
    localparam logic [OP_W-1:0] OP_SQUARE = 2'd0;
    localparam logic [OP_W-1:0] OP_SUM    = 2'd1;
    localparam logic [OP_W-1:0] OP_MAX    = 2'd2;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } out_beat_t;

    typedef struct packed {
        logic [TERM_W-1:0] term;
        logic [OP_W-1:0]   op;
        logic              last;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic pop;
        logic root_busy;
    } back_status_t;

endpackage

@@ hdl/vdu_front.sv @@
// Front end: accepts element pairs, forms the magnitude of the difference and the term.
`timescale 1ns / 1ps

module vdu_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [vdu_pkg::MODE_W-1:0]  mode,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  vdu_pkg::in_beat_t           in_data,
    input  vdu_pkg::queue_status_t      q_status,
    output logic                        push,
    output vdu_pkg::work_t              push_data
);

    logic                              f_valid_reg;
    logic                              f_valid_next;
    logic [vdu_pkg::DIFF_W-1:0]        f_mag_reg;
    logic [vdu_pkg::OP_W-1:0]          f_op_reg;
    logic                              f_last_reg;
    logic                              accept;
    logic signed [vdu_pkg::DIFF_W-1:0] diff;
    logic [vdu_pkg::DIFF_W-1:0]        mag;
    logic [vdu_pkg::OP_W-1:0]          op;
    logic [vdu_pkg::TERM_W-1:0]        square;

    assign push     = f_valid_reg && !q_status.full;
    assign in_stall = f_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        diff = {in_data.elem_a[vdu_pkg::ELEM_W-1], in_data.elem_a}
             - {in_data.elem_b[vdu_pkg::ELEM_W-1], in_data.elem_b};
        mag  = diff[vdu_pkg::DIFF_W-1] ? vdu_pkg::DIFF_W'(-diff) : vdu_pkg::DIFF_W'(diff);
        if (mode == vdu_pkg::MODE_EUCLID)
            op = vdu_pkg::OP_SQUARE;
        else if (mode == vdu_pkg::MODE_MANHATTAN)
            op = vdu_pkg::OP_SUM;
        else
            op = vdu_pkg::OP_MAX;
    end

    // Square on the way into the queue; the queue entry registers the product.
    always_comb
    begin
        square = vdu_pkg::TERM_W'(f_mag_reg) * vdu_pkg::TERM_W'(f_mag_reg);
        push_data.op   = f_op_reg;
        push_data.last = f_last_reg;
        if (f_op_reg == vdu_pkg::OP_SQUARE)
            push_data.term = square;
        else
            push_data.term = vdu_pkg::TERM_W'(f_mag_reg);
    end

    always_comb
    begin
        if (accept)
            f_valid_next = 1'b1;
        else if (push)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_mag_reg  <= mag;
            f_op_reg   <= op;
            f_last_reg <= in_data.last;
        end
    end

endmodule

@@ hdl/vdu_queue.sv @@
// Small work queue between the front end and the accumulate/root back end.
`timescale 1ns / 1ps

module vdu_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  vdu_pkg::work_t         wr_data,
    input  logic                   pop,
    output vdu_pkg::work_t         rd_data,
    output vdu_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vdu_pkg::work_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ hdl/vdu_back.sv @@
// Back end: saturating accumulate or running maximum, iterative square root, result register.
`timescale 1ns / 1ps

module vdu_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  vdu_pkg::work_t        q_data,
    output vdu_pkg::back_status_t status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output vdu_pkg::out_beat_t    out_data
);

    localparam logic ST_ACCUM = 1'b0;
    localparam logic ST_ROOT  = 1'b1;

    localparam int ACC_W  = vdu_pkg::ACC_W;
    localparam int DIST_W = vdu_pkg::DIST_W;

    logic               state_reg;
    logic               state_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [ACC_W-1:0]   rad_reg;
    logic [ACC_W-1:0]   rad_next;
    logic [ACC_W-1:0]   root_reg;
    logic [ACC_W-1:0]   root_next;
    logic [ACC_W-1:0]   bit_reg;
    logic [ACC_W-1:0]   bit_next;
    logic               root_sat_reg;
    logic               root_sat_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    vdu_pkg::out_beat_t out_data_reg;
    vdu_pkg::out_beat_t out_data_next;

    logic               slot_free;
    logic               pop;
    logic [ACC_W:0]     sum;
    logic [ACC_W-1:0]   upd;
    logic               upd_ovf;
    logic [ACC_W-1:0]   trial;
    logic               fits;
    logic [ACC_W-1:0]   rad_step;
    logic [ACC_W-1:0]   root_step;
    logic               root_adv;

    assign slot_free        = !out_valid_reg || !out_stall;
    assign pop              = (state_reg == ST_ACCUM) && q_valid && (!q_data.last || slot_free);
    assign root_adv         = (state_reg == ST_ROOT) && (!bit_reg[0] || slot_free);
    assign status.pop       = pop;
    assign status.root_busy = (state_reg == ST_ROOT);
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

    // Accumulator update for the entry at the queue head
    always_comb
    begin
        sum     = {1'b0, acc_reg} + (ACC_W + 1)'(q_data.term);
        upd     = acc_reg;
        upd_ovf = ovf_reg;
        case (q_data.op)
            vdu_pkg::OP_MAX:
            begin
                if (ACC_W'(q_data.term) > acc_reg)
                    upd = ACC_W'(q_data.term);
            end
            vdu_pkg::OP_SUM, vdu_pkg::OP_SQUARE:
            begin
                if (sum[ACC_W])
                begin
                    upd     = '1;
                    upd_ovf = 1'b1;
                end
                else
                    upd = sum[ACC_W-1:0];
            end
            default:
            begin
                upd = acc_reg;
            end
        endcase
    end

    // One digit of the restoring square root per cycle, the last once the result slot is free
    always_comb
    begin
        trial     = root_reg + bit_reg;
        fits      = (rad_reg >= trial);
        rad_step  = fits ? rad_reg - trial : rad_reg;
        root_step = fits ? (root_reg >> 1) + bit_reg : (root_reg >> 1);
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        root_sat_next  = root_sat_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (pop)
                begin
                    if (!q_data.last)
                    begin
                        acc_next = upd;
                        ovf_next = upd_ovf;
                    end
                    else
                    begin
                        acc_next = '0;
                        ovf_next = 1'b0;
                        if (q_data.op == vdu_pkg::OP_SQUARE)
                        begin
                            state_next    = ST_ROOT;
                            rad_next      = upd;
                            root_next     = '0;
                            bit_next      = ACC_W'(1) << (ACC_W - 2);
                            root_sat_next = upd_ovf;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            if (upd > ACC_W'({DIST_W{1'b1}}))
                            begin
                                out_data_next.distance  = '1;
                                out_data_next.saturated = 1'b1;
                            end
                            else
                            begin
                                out_data_next.distance  = upd[DIST_W-1:0];
                                out_data_next.saturated = upd_ovf;
                            end
                        end
                    end
                end
            end
            ST_ROOT:
            begin
                if (root_adv)
                begin
                    rad_next  = rad_step;
                    root_next = root_step;
                    bit_next  = bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_next              = ST_ACCUM;
                        out_valid_next          = 1'b1;
                        out_data_next.distance  = root_step[DIST_W-1:0];
                        out_data_next.saturated = root_sat_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        root_sat_reg <= root_sat_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ hdl/vector_distance_unit_core.sv @@
// Top level of the vector distance unit: mode register, front end, work queue, back end.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one element pair per beat (elem_a, elem_b, last). Hold elem_b at
//           zero to get a norm of elem_a. The beat with last set closes a vector.
//   out_* : one beat per vector: distance (24 bits, clamped) and a saturated
//           flag for accumulator or output clamping.
//   cfg_* : writes the 2-bit mode (0 Euclidean, 1 Manhattan, 2 or 3 maximum
//           absolute difference). Always ready; write only while the unit is idle.
// Throughput: one pair per cycle while streaming. The Euclidean square root
// runs once per vector in the back end, one root digit per cycle; during it
// the queue of QUEUE_DEPTH entries plus the front register absorb the next
// vector's pairs, then in_stall rises.
// From the last beat to out_valid the result passes the front register, a
// queue entry and the result register; Euclidean adds the root steps.
// Reset: clears mode to Euclidean, the accumulator, the overflow flag, the
// queue and all valids.
// A receiver stall holds the result beat; the back end stops at the next
// result until the beat is taken, and the queue and front then fill and stall.

module vector_distance_unit_core
#(
    parameter int QUEUE_DEPTH = 4   // 2 to 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  vdu_pkg::in_beat_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output vdu_pkg::out_beat_t         out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [vdu_pkg::MODE_W-1:0] cfg_data
);

    logic [vdu_pkg::MODE_W-1:0] mode_reg;
    logic [vdu_pkg::MODE_W-1:0] mode_next;
    logic                       push;
    vdu_pkg::work_t             push_data;
    vdu_pkg::work_t             head_data;
    vdu_pkg::queue_status_t     q_status;
    vdu_pkg::back_status_t      b_status;

    // The mode register takes a write beat in any cycle.
    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= vdu_pkg::MODE_EUCLID;
        else
            mode_reg <= mode_next;
    end

    // Front end: classify the pair by mode, square for Euclidean.
    vdu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple the front from the back so each can stall on its own.
    vdu_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (b_status.pop),
        .rd_data (head_data),
        .status  (q_status)
    );

    // Back end: accumulate, take the root, drive the result beat.
    vdu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_status.empty),
        .q_data    (head_data),
        .status    (b_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    // No queue entry is consumed while the square root is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_status.root_busy |-> !b_status.pop)
        else $error("queue popped during square root");

    // The back end only pops a non-empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_status.pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // The front end stalls its input only when the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_status.full)
        else $error("input stalled with room in queue");
`endif

endmodule
